FILE: hdl/csi_pkg.sv
// Shared types and constants for the charge slot status indicator.
// Used by csi_timebase, csi_slot_lane and charge_slot_status_indicator.
package csi_pkg;

   localparam int READING_W = 10;
   localparam int SECONDS_W = 17;
   localparam int TICKS_W   = 14;
   localparam int SUBSEC_W  = 10;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [READING_W-1:0] READING_RESET  = 10'd1023;
   localparam logic [SECONDS_W-1:0] SECONDS_MAX    = 17'd131071;
   localparam logic [TICKS_W-1:0]   TOGGLE_MAX     = 14'd16383;

   localparam logic [READING_W-1:0] THRESHOLD_RESET = 10'd500;
   localparam logic [SECONDS_W-1:0] PERIOD_RESET    = 17'd86400;
   localparam logic [TICKS_W-1:0]   BLINK_RESET     = 14'd500;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_PERIOD    = 2'd1;
   localparam logic [1:0] REG_BLINK     = 2'd2;

   // item kind on req_tuser
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic sec_pulse;
      logic toggle;
      logic on_phase;
   } timebase_type;

   typedef struct packed {
      logic lamp;
      logic charging;
      logic present;
   } slot_status_type;

endpackage

FILE: hdl/charge_slot_status_indicator.sv
// Charge slot status indicator, top level: CSR block, timebase, slot lanes,
// mask merge and output skid stage. Depends on csi_pkg, csi_timebase, csi_slot_lane.
// Result goes to the output register, or to the skid entry when the output stalls.
// One item per cycle while skid is empty; all lanes update in the accept cycle.
// Reset: synchronous; registers return to defaults, slots read absent, LEDs dark.
// A two-entry output stage keeps req_tready high while only one result waits.
module charge_slot_status_indicator
   import csi_pkg::*;
#(
   parameter int SLOT_COUNT       = 4,
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic                  clock,
   input  logic                  reset,
   // reading_slot0 .. reading_slot(N-1), 10 bits each, zero padded
   input  logic [((READING_W*SLOT_COUNT+7)/8)*8-1:0] req_tdata,
   input  logic                  req_tuser,   // op
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // lamp_mask, charging_mask, present_mask (N bits each), zero padded
   output logic [((3*SLOT_COUNT+7)/8)*8-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int RSP_W = ((3*SLOT_COUNT+7)/8)*8;

   logic [READING_W-1:0] thr_ff;
   logic [SECONDS_W-1:0] period_ff;
   logic [TICKS_W-1:0]   blink_ff;
   logic                 csr_write;
   logic [1:0]           csr_index;

   logic                 accept;
   timebase_type         tb;
   slot_status_type      lane_status [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] lamp_mask, charging_mask, present_mask;
   logic [RSP_W-1:0]     result;

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [RSP_W-1:0]     main_data_ff, main_data_in;
   logic [RSP_W-1:0]     skid_data_ff, skid_data_in;
   logic                 take;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLD_RESET;
         period_ff <= PERIOD_RESET;
         blink_ff  <= BLINK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_THRESHOLD: thr_ff    <= csr_pwdata[READING_W-1:0];
            REG_PERIOD:    period_ff <= csr_pwdata[SECONDS_W-1:0];
            REG_BLINK:     blink_ff  <= csr_pwdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_THRESHOLD: csr_prdata = CSR_DATA_W'(thr_ff);
         REG_PERIOD:    csr_prdata = CSR_DATA_W'(period_ff);
         REG_BLINK:     csr_prdata = CSR_DATA_W'(blink_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   csi_timebase #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) u_timebase (
      .clock        (clock),
      .reset        (reset),
      .tick_accept  (accept && (req_tuser == OP_TICK)),
      .blink_period (blink_ff),
      .tb           (tb)
   );

   for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_lane
      csi_slot_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .accept    (accept),
         .op        (req_tuser),
         .reading   (req_tdata[s*READING_W +: READING_W]),
         .threshold (thr_ff),
         .period    (period_ff),
         .tb        (tb),
         .status    (lane_status[s])
      );
      assign lamp_mask[s]     = lane_status[s].lamp;
      assign charging_mask[s] = lane_status[s].charging;
      assign present_mask[s]  = lane_status[s].present;
   end

   assign result = RSP_W'({present_mask, charging_mask, lamp_mask});

   // output register plus skid entry
   assign take       = main_valid_ff && rsp_tready;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || take) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = accept;
            main_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

FILE: hdl/csi_timebase.sv
// Millisecond timebase: subsecond counter, blink toggle counter and phase.
// Depends on csi_pkg.
module csi_timebase
   import csi_pkg::*;
#(
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick_accept,
   input  logic [TICKS_W-1:0] blink_period,
   output timebase_type       tb
);

   logic [SUBSEC_W-1:0] sub_ff, sub_in, sub_inc;
   logic [TICKS_W-1:0]  tog_ff, tog_in, tog_inc;
   logic                phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         tog_ff   <= TOGGLE_MAX;
         phase_ff <= 1'b1;
      end else begin
         sub_ff   <= sub_in;
         tog_ff   <= tog_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      sub_in      = sub_ff;
      tog_in      = tog_ff;
      phase_in    = phase_ff;
      tb.sec_pulse = 1'b0;
      tb.toggle    = 1'b0;
      tb.on_phase  = phase_ff;
      sub_inc = sub_ff + 1'b1;
      tog_inc = (tog_ff != TOGGLE_MAX) ? tog_ff + 1'b1 : tog_ff;
      if (tick_accept) begin
         if (sub_inc >= SUBSEC_W'(TICKS_PER_SECOND)) begin
            sub_in       = '0;
            tb.sec_pulse = 1'b1;
         end else begin
            sub_in = sub_inc;
         end
         if (tog_inc > blink_period) begin
            tog_in    = '0;
            tb.toggle = 1'b1;
            phase_in  = !phase_ff;
         end else begin
            tog_in = tog_inc;
         end
      end
   end

endmodule

FILE: hdl/csi_slot_lane.sv
// One slot lane: stored reading, seconds count, charging flag and LED state.
// Depends on csi_pkg.
module csi_slot_lane
   import csi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 op,
   input  logic [READING_W-1:0] reading,
   input  logic [READING_W-1:0] threshold,
   input  logic [SECONDS_W-1:0] period,
   input  timebase_type         tb,
   output slot_status_type      status
);

   logic [READING_W-1:0] last_ff, last_in;
   logic [SECONDS_W-1:0] secs_ff, secs_in, secs_mid;
   logic                 chg_ff, chg_in, chg_mid;
   logic                 lamp_ff, lamp_in;
   logic                 present_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= READING_RESET;
         secs_ff <= '0;
         chg_ff  <= 1'b1;
         lamp_ff <= 1'b0;
      end else begin
         last_ff <= last_in;
         secs_ff <= secs_in;
         chg_ff  <= chg_in;
         lamp_ff <= lamp_in;
      end
   end

   always_comb begin
      present_now = last_ff < threshold;
      last_in  = last_ff;
      secs_in  = secs_ff;
      chg_in   = chg_ff;
      lamp_in  = lamp_ff;
      secs_mid = secs_ff;
      chg_mid  = chg_ff;
      if (accept) begin
         if (op == OP_SAMPLE) begin
            // old reading above threshold: fresh plug-in
            if (last_ff > threshold) begin
               secs_mid = '0;
               chg_mid  = 1'b1;
            end
            last_in = reading;
            secs_in = secs_mid;
            chg_in  = (secs_mid > period) ? 1'b0 : chg_mid;
         end else begin
            if (tb.sec_pulse && present_now && secs_ff != SECONDS_MAX) begin
               secs_in = secs_ff + 1'b1;
            end
            if (tb.toggle) begin
               if (tb.on_phase) begin
                  lamp_in = present_now;
               end else if (present_now && chg_ff) begin
                  lamp_in = 1'b0;
               end
            end
         end
      end
      status.lamp     = lamp_in;
      status.charging = chg_in;
      status.present  = last_in < threshold;
   end

endmodule
